// ===== rtl/weighted_row_regression_estimate_defines.svh =====
// Assertion macros used by the RTL controller.
`ifndef WEIGHTED_ROW_REGRESSION_ESTIMATE_DEFINES_SVH
`define WEIGHTED_ROW_REGRESSION_ESTIMATE_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define WRRE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the following cycle.
`define WRRE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/wrre_pkg.sv =====
`default_nettype none
package wrre_pkg;
    localparam int unsigned FracBitsDefault = 16;
    localparam int unsigned FracBitsMin     = 8;
    localparam int unsigned FracBitsMax     = 24;

    localparam logic [1:0] StatusOk       = 2'd0;
    localparam logic [1:0] StatusZeroVar  = 2'd1;
    localparam logic [1:0] StatusZeroDen  = 2'd2;

    typedef struct packed {
        logic signed [31:0] observation;
        logic        [31:0] variance;
        logic signed [31:0] factor_value;
        logic               row_end;
    } t_in_req;

    typedef struct packed {
        logic signed [31:0] coefficient;
        logic        [31:0] standard_error;
        logic        [1:0]  status;
    } t_out_req;

    // Datapath operations requested by the controller.
    typedef enum logic [3:0] {
        OpNone,
        OpLoad,      // capture request, form f*f and |y*f|
        OpDivInitW,  // start dividing f*f by v
        OpDivInitP,  // start dividing |y*f| by v
        OpDivStep,   // one restoring-division step
        OpAccW,      // add weight term
        OpAccP,      // add product term
        OpRowInitQ,  // start P/W
        OpRowInitN,  // start 2^(3F)/W
        OpCoefFix,   // saturate and keep coefficient
        OpSqrtInit,  // start integer root
        OpSqrtStep,  // one root step
        OpFinish     // build result, clear accumulators
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic var_zero;
        logic row_end;
        logic div_done;
        logic sqrt_done;
        logic w_zero;
    } t_sts;
endpackage
`default_nettype wire

// ===== rtl/weighted_row_regression_estimate.sv =====
// Weighted least-squares coefficient over one streamed row.
// Input channel: i_in_valid / o_in_stall with i_in (observation, variance,
// factor value, row_end). One request per row element.
// Output channel: o_out_valid / i_out_stall with o_out (coefficient,
// standard error, status), one request per row, on the row_end element.
// Each element runs two 64-step divisions through one shared restoring
// divider, both skipped when its variance is zero. A row_end element
// adds two more divisions and a 32-step root, skipped with a zero weight
// sum; the next element can be taken in the cycle its result becomes
// valid. The divider yields one quotient bit a cycle.
// The result sits in an output register; the next element is taken while it
// waits, but a following row end holds until the register is free.
// Reset (synchronous, active low) clears the accumulators, the zero-variance
// flag, the controller and the output valid.
// A stalled result holds its value until taken.
`default_nettype none
module weighted_row_regression_estimate #(
    parameter int unsigned FRAC_BITS = wrre_pkg::FracBitsDefault
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  wrre_pkg::t_in_req   i_in,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output wrre_pkg::t_out_req  o_out
);
    wrre_pkg::t_cmd cmd;
    wrre_pkg::t_sts sts;

    // Controller sequences the shared divider and root unit.
    wrre_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Datapath holds accumulators, divider, root and result register.
    wrre_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_in),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_res   (o_out)
    );
endmodule
`default_nettype wire

// ===== rtl/wrre_datapath.sv =====
`default_nettype none
module wrre_datapath #(
    parameter int unsigned FRAC_BITS = wrre_pkg::FracBitsDefault
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wrre_pkg::t_in_req   i_req,
    input  wrre_pkg::t_cmd      i_cmd,
    output wrre_pkg::t_sts      o_sts,
    output wrre_pkg::t_out_req  o_res
);
    localparam int unsigned NumExp = 3 * FRAC_BITS;

    // Captured request and per-element products (64-bit magnitudes).
    logic [31:0] r_var, n_var;
    logic        r_end, n_end;
    logic [63:0] r_ff, n_ff;
    logic [63:0] r_pf, n_pf;
    logic        r_pneg, n_pneg;

    // Shared restoring divider: 128-bit dividend by 64-bit divisor, one bit a cycle.
    logic [63:0]  r_rem, n_rem;
    logic [127:0] r_dvd, n_dvd;
    logic [63:0]  r_dvs, n_dvs;
    logic [63:0]  r_quo, n_quo;
    logic [6:0]   r_cnt, n_cnt;
    logic         r_ovf, n_ovf;

    // Accumulators.
    logic [63:0]        r_wsum, n_wsum;
    logic signed [63:0] r_psum, n_psum;
    logic               r_zv, n_zv;

    // Root unit.
    logic [63:0] r_sx, n_sx;
    logic [63:0] r_sres, n_sres;
    logic [63:0] r_sbit, n_sbit;

    logic [31:0] r_coef, n_coef;
    wrre_pkg::t_out_req r_res, n_res;

    logic [32:0] f_mag, y_mag;
    logic [63:0] quo_sat;
    logic [64:0] rem_sh;
    logic        take;
    logic [64:0] wadd;
    logic signed [64:0] padd;
    logic signed [64:0] pterm;
    logic [63:0] pmag;
    logic [64:0] rb;
    logic [63:0] nbig;

    always_comb begin
        f_mag = i_req.factor_value[31] ? 33'(-{i_req.factor_value[31], i_req.factor_value})
                                       : {1'b0, i_req.factor_value};
        y_mag = i_req.observation[31] ? 33'(-{i_req.observation[31], i_req.observation})
                                      : {1'b0, i_req.observation};
        quo_sat = r_ovf ? {64{1'b1}} : r_quo;
        rem_sh  = {r_rem, r_dvd[127]};
        take    = rem_sh >= {1'b0, r_dvs};
        wadd    = {1'b0, r_wsum} + {1'b0, quo_sat};
        pterm   = r_pneg ? -$signed({1'b0, quo_sat}) : $signed({1'b0, quo_sat});
        padd    = {r_psum[63], r_psum} + pterm;
        pmag    = r_psum[63] ? 64'(-r_psum) : 64'(r_psum);
        rb      = {1'b0, r_sres} + {1'b0, r_sbit};
        nbig    = '0;
        if (NumExp < 64) begin
            nbig[NumExp[5:0]] = 1'b1;
        end
    end

    always_comb begin
        n_var = r_var; n_end = r_end; n_ff = r_ff; n_pf = r_pf; n_pneg = r_pneg;
        n_rem = r_rem; n_dvd = r_dvd; n_dvs = r_dvs; n_quo = r_quo; n_cnt = r_cnt;
        n_ovf = r_ovf; n_wsum = r_wsum; n_psum = r_psum; n_zv = r_zv;
        n_sx = r_sx; n_sres = r_sres; n_sbit = r_sbit; n_coef = r_coef; n_res = r_res;
        unique case (i_cmd.op)
            wrre_pkg::OpLoad: begin
                n_var  = i_req.variance;
                n_end  = i_req.row_end;
                n_ff   = 64'(f_mag) * 64'(f_mag);
                n_pf   = 64'(y_mag) * 64'(f_mag);
                n_pneg = i_req.observation[31] ^ i_req.factor_value[31];
                if (i_req.variance == '0) begin
                    n_zv = 1'b1;
                end
            end
            wrre_pkg::OpDivInitW: begin
                n_rem = '0; n_dvd = {r_ff, 64'd0}; n_dvs = {32'd0, r_var};
                n_quo = '0; n_cnt = 7'd64; n_ovf = 1'b0;
            end
            wrre_pkg::OpDivInitP: begin
                n_rem = '0; n_dvd = {r_pf, 64'd0}; n_dvs = {32'd0, r_var};
                n_quo = '0; n_cnt = 7'd64; n_ovf = 1'b0;
            end
            wrre_pkg::OpRowInitQ: begin
                n_rem = 64'(pmag >> (64 - FRAC_BITS));
                n_dvd = {64'(pmag << FRAC_BITS), 64'd0};
                n_dvs = r_wsum; n_quo = '0; n_cnt = 7'd64;
                n_ovf = 64'(pmag >> (64 - FRAC_BITS)) >= r_wsum;
            end
            wrre_pkg::OpRowInitN: begin
                n_rem = (NumExp >= 64) ? 64'(64'd1 << (NumExp - 64)) : 64'd0;
                n_dvd = {nbig, 64'd0};
                n_dvs = r_wsum; n_quo = '0; n_cnt = 7'd64;
                n_ovf = ((NumExp >= 64) ? 64'(64'd1 << (NumExp - 64)) : 64'd0) >= r_wsum;
            end
            wrre_pkg::OpDivStep: begin
                n_dvd = {r_dvd[126:0], 1'b0};
                n_quo = {r_quo[62:0], take};
                n_rem = take ? 64'(rem_sh - {1'b0, r_dvs}) : rem_sh[63:0];
                n_cnt = r_cnt - 7'd1;
            end
            wrre_pkg::OpAccW: begin
                if (r_var != '0) begin
                    n_wsum = wadd[64] ? {64{1'b1}} : wadd[63:0];
                end
            end
            wrre_pkg::OpAccP: begin
                if (r_var != '0) begin
                    if (padd[64] != padd[63]) begin
                        n_psum = padd[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
                    end else begin
                        n_psum = padd[63:0];
                    end
                end
            end
            wrre_pkg::OpCoefFix: begin
                if (r_psum[63]) begin
                    n_coef = (quo_sat > 64'h8000_0000) ? 32'h8000_0000
                                                      : 32'(64'd0 - quo_sat);
                end else begin
                    n_coef = (quo_sat > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : quo_sat[31:0];
                end
            end
            wrre_pkg::OpSqrtInit: begin
                n_sx = quo_sat; n_sres = '0; n_sbit = {2'b01, 62'd0};
            end
            wrre_pkg::OpSqrtStep: begin
                if (r_sbit <= r_sx && r_sx >= rb[63:0] && !rb[64]) begin
                    n_sx   = r_sx - rb[63:0];
                    n_sres = (r_sres >> 1) + r_sbit;
                end else if (r_sbit <= r_sx || r_sres != '0) begin
                    n_sres = r_sres >> 1;
                end
                n_sbit = r_sbit >> 2;
            end
            wrre_pkg::OpFinish: begin
                if (r_wsum == '0) begin
                    n_res.coefficient    = '0;
                    n_res.standard_error = '1;
                    n_res.status         = wrre_pkg::StatusZeroDen;
                end else begin
                    n_res.coefficient    = r_coef;
                    n_res.standard_error = (r_sres > 64'hFFFF_FFFF) ? '1 : r_sres[31:0];
                    n_res.status = r_zv ? wrre_pkg::StatusZeroVar : wrre_pkg::StatusOk;
                end
                n_wsum = '0; n_psum = '0; n_zv = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wsum <= '0;
            r_psum <= '0;
            r_zv   <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_wsum <= n_wsum;
            r_psum <= n_psum;
            r_zv   <= n_zv;
            r_cnt  <= n_cnt;
        end
        r_var <= n_var; r_end <= n_end; r_ff <= n_ff; r_pf <= n_pf; r_pneg <= n_pneg;
        r_rem <= n_rem; r_dvd <= n_dvd; r_dvs <= n_dvs; r_quo <= n_quo; r_ovf <= n_ovf;
        r_sx <= n_sx; r_sres <= n_sres; r_sbit <= n_sbit; r_coef <= n_coef; r_res <= n_res;
    end

    assign o_sts.var_zero  = (r_var == '0);
    assign o_sts.row_end   = r_end;
    assign o_sts.div_done  = (r_cnt == '0);
    assign o_sts.sqrt_done = (r_sbit == '0);
    assign o_sts.w_zero    = (r_wsum == '0);
    assign o_res = r_res;
endmodule
`default_nettype wire

// ===== rtl/wrre_ctrl.sv =====
`default_nettype none
`include "weighted_row_regression_estimate_defines.svh"
module wrre_ctrl (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_in_valid,
    output logic           o_in_stall,
    output logic           o_out_valid,
    input  wire            i_out_stall,
    input  wrre_pkg::t_sts i_sts,
    output wrre_pkg::t_cmd o_cmd
);
    localparam logic [3:0] StIdle  = 4'd0;
    localparam logic [3:0] StDivW0 = 4'd1;
    localparam logic [3:0] StDivW  = 4'd2;
    localparam logic [3:0] StAccW  = 4'd3;
    localparam logic [3:0] StDivP0 = 4'd4;
    localparam logic [3:0] StDivP  = 4'd5;
    localparam logic [3:0] StAccP  = 4'd6;
    localparam logic [3:0] StRowQ  = 4'd7;
    localparam logic [3:0] StCoef  = 4'd8;
    localparam logic [3:0] StRowN  = 4'd9;
    localparam logic [3:0] StSqI   = 4'd10;
    localparam logic [3:0] StSq    = 4'd11;
    localparam logic [3:0] StFin   = 4'd12;
    localparam logic [3:0] StOut   = 4'd13;
    localparam logic [3:0] StQDiv  = 4'd14;
    localparam logic [3:0] StNDiv  = 4'd15;

    logic [3:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       accept;

    assign accept = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != StIdle);

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd.op    = wrre_pkg::OpNone;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            StIdle: if (accept) begin
                o_cmd.op = wrre_pkg::OpLoad;
                n_state  = StDivW0;
            end
            StDivW0: begin
                o_cmd.op = wrre_pkg::OpDivInitW;
                n_state  = i_sts.var_zero ? StAccP : StDivW;
            end
            StDivW: begin
                if (i_sts.div_done) begin
                    n_state = StAccW;
                end else begin
                    o_cmd.op = wrre_pkg::OpDivStep;
                end
            end
            StAccW: begin
                o_cmd.op = wrre_pkg::OpAccW;
                n_state  = StDivP0;
            end
            StDivP0: begin
                o_cmd.op = wrre_pkg::OpDivInitP;
                n_state  = StDivP;
            end
            StDivP: begin
                if (i_sts.div_done) begin
                    n_state = StAccP;
                end else begin
                    o_cmd.op = wrre_pkg::OpDivStep;
                end
            end
            StAccP: begin
                o_cmd.op = wrre_pkg::OpAccP;
                n_state  = i_sts.row_end ? StRowQ : StIdle;
            end
            StRowQ: begin
                if (i_sts.w_zero) begin
                    n_state = StFin;
                end else begin
                    o_cmd.op = wrre_pkg::OpRowInitQ;
                    n_state  = StQDiv;
                end
            end
            StQDiv: begin
                if (i_sts.div_done) begin
                    n_state = StCoef;
                end else begin
                    o_cmd.op = wrre_pkg::OpDivStep;
                end
            end
            StCoef: begin
                o_cmd.op = wrre_pkg::OpCoefFix;
                n_state  = StRowN;
            end
            StRowN: begin
                o_cmd.op = wrre_pkg::OpRowInitN;
                n_state  = StNDiv;
            end
            StNDiv: begin
                if (i_sts.div_done) begin
                    n_state = StSqI;
                end else begin
                    o_cmd.op = wrre_pkg::OpDivStep;
                end
            end
            StSqI: begin
                o_cmd.op = wrre_pkg::OpSqrtInit;
                n_state  = StSq;
            end
            StSq: begin
                if (i_sts.sqrt_done) begin
                    n_state = StFin;
                end else begin
                    o_cmd.op = wrre_pkg::OpSqrtStep;
                end
            end
            StFin: begin
                // Load the result once the register is empty or being emptied.
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.op    = wrre_pkg::OpFinish;
                    n_out_valid = 1'b1;
                    n_state     = StIdle;
                end
            end
            default: n_state = StIdle;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= StIdle;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    `WRRE_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n, r_state != StIdle, o_in_stall, "accept while busy")
    `WRRE_ASSERT_NEXT(a_fin_valid, i_clk, i_rst_n, o_cmd.op == wrre_pkg::OpFinish, r_out_valid, "finish without result")
    `WRRE_ASSERT_NEXT(a_load_leaves_idle, i_clk, i_rst_n, accept, r_state == StDivW0, "load did not start work")
endmodule
`default_nettype wire
